>>> rtl/dtq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the deadline timer queue.
// Used by the channel interfaces, the entry store, the controller and the top level.
package dtq_pkg;

	// Queue geometry.
	localparam int CAPACITY  = 16;
	localparam int TIME_BITS = 32;
	localparam int ID_W      = 4;
	localparam int ID_COUNT  = 16;
	localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int POP_W     = $clog2(ID_COUNT + 1);

	// Command codes.
	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_TICK   = 2'd1,
		MODE_CANCEL = 2'd2
	} mode_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_INSERTED   = 3'd0,
		ST_FULL       = 3'd1,
		ST_DUPLICATE  = 3'd2,
		ST_CANCELLED  = 3'd3,
		ST_NOT_QUEUED = 3'd4,
		ST_EXPIRED    = 3'd5,
		ST_NONE       = 3'd6
	} status_t;

	// One queue cell.
	typedef struct packed {
		logic [TIME_BITS-1:0] deadline;
		logic [ID_W-1:0]      id;
	} entry_t;

	// Access request to the entry store.
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		entry_t            wr_data;
	} mem_req_t;

	// One result item.
	typedef struct packed {
		status_t              status;
		logic [ID_W-1:0]      id;
		logic [TIME_BITS-1:0] deadline;
		logic                 last;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/dtq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for commands and results.
// Depends on dtq_pkg for widths.
interface dtq_cmd_if import dtq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           mode;
	logic [ID_W-1:0]      entry_id;
	logic [TIME_BITS-1:0] deadline;
	logic [TIME_BITS-1:0] now_time;

	modport source (output valid, mode, entry_id, deadline, now_time, input ready);
	modport sink (input valid, mode, entry_id, deadline, now_time, output ready);
endinterface

interface dtq_rsp_if import dtq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [2:0]           status;
	logic [ID_W-1:0]      result_id;
	logic [TIME_BITS-1:0] result_deadline;
	logic                 last;

	modport source (output valid, status, result_id, result_deadline, last, input ready);
	modport sink (input valid, status, result_id, result_deadline, last, output ready);
endinterface
`default_nettype wire

>>> rtl/dtq_store.sv
`timescale 1ns / 1ps
`default_nettype none
// Entry store: one synchronous memory of queue cells, one write and one read per cycle.
// Depends on dtq_pkg for the cell type and address width.
module dtq_store import dtq_pkg::*; (
	input  wire logic     clk,
	input  wire mem_req_t req,
	output entry_t        rd_data
);

	entry_t mem [CAPACITY];

	// Write port.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/dtq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequencer of the timer queue: insert, cancel and tick over a circular buffer in the store.
// Depends on dtq_pkg and dtq_cmd_if; drives dtq_store and the result register of the top level.
module dtq_ctrl import dtq_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	dtq_cmd_if.sink     cmd,
	output mem_req_t    mem_req,
	input  wire entry_t rd_data,
	input  wire logic   res_free,
	output logic        res_push,
	output result_t     res_data
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_INS_CMP  = 7'b0000010,
		S_INS_PUT  = 7'b0000100,
		S_CAN_CMP  = 7'b0001000,
		S_CAN_SH   = 7'b0010000,
		S_TICK_CMP = 7'b0100000,
		S_DONE     = 7'b1000000
	} state_t;

	localparam logic [ADDR_W:0] CapExt = (ADDR_W + 1)'(CAPACITY);

	state_t               state_q, state_n;
	logic [ADDR_W-1:0]    head_q, head_n;
	logic [CNT_W-1:0]     count_q, count_n;
	logic [ID_COUNT-1:0]  queued_q, queued_n;
	logic [ADDR_W-1:0]    pos_q, pos_n;
	logic [POP_W-1:0]     pops_q, pops_n;
	logic [ID_W-1:0]      id_q, id_n;
	logic [TIME_BITS-1:0] dl_q, dl_n;
	logic [TIME_BITS-1:0] now_q, now_n;
	logic                 pend_v_q, pend_v_n;
	entry_t               pend_q, pend_n;
	status_t              fin_status_q, fin_status_n;
	entry_t               fin_q, fin_n;
	logic [CNT_W-1:0]     pos_ext;
	logic [CNT_W-1:0]     pos_up;
	logic                 expire;

	// Logical queue place to memory address, wrapping at the capacity.
	function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] h,
			input logic [ADDR_W-1:0] l);
		logic [ADDR_W:0] s;
		s = {1'b0, h} + {1'b0, l};
		if (s >= CapExt) begin
			s = s - CapExt;
		end
		return s[ADDR_W-1:0];
	endfunction

	assign cmd.ready = (state_q == S_IDLE);
	assign pos_ext   = CNT_W'(pos_q);
	assign pos_up    = pos_ext + CNT_W'(1);
	assign expire    = (now_q >= rd_data.deadline) && (pops_q < POP_W'(ID_COUNT));

	// Next-state logic of the sequencer.
	always_comb begin
		state_n      = state_q;
		head_n       = head_q;
		count_n      = count_q;
		queued_n     = queued_q;
		pos_n        = pos_q;
		pops_n       = pops_q;
		id_n         = id_q;
		dl_n         = dl_q;
		now_n        = now_q;
		pend_v_n     = pend_v_q;
		pend_n       = pend_q;
		fin_status_n = fin_status_q;
		fin_n        = fin_q;
		mem_req      = '0;
		res_push     = 1'b0;
		res_data     = '0;

		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					id_n  = cmd.entry_id;
					dl_n  = cmd.deadline;
					now_n = cmd.now_time;
					fin_n = '{deadline: '0, id: cmd.entry_id};
					case (cmd.mode)
						MODE_INSERT: begin
							if (queued_q[cmd.entry_id]) begin
								fin_status_n = ST_DUPLICATE;
								state_n      = S_DONE;
							end else if (count_q == CNT_W'(CAPACITY)) begin
								fin_status_n = ST_FULL;
								state_n      = S_DONE;
							end else if (count_q == '0) begin
								mem_req.wr_en   = 1'b1;
								mem_req.wr_addr = head_q;
								mem_req.wr_data = '{deadline: cmd.deadline, id: cmd.entry_id};
								count_n         = count_q + CNT_W'(1);
								queued_n[cmd.entry_id] = 1'b1;
								fin_status_n    = ST_INSERTED;
								state_n         = S_DONE;
							end else begin
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = phys(head_q, ADDR_W'(count_q - CNT_W'(1)));
								pos_n           = ADDR_W'(count_q);
								state_n         = S_INS_CMP;
							end
						end
						MODE_CANCEL: begin
							if (!queued_q[cmd.entry_id]) begin
								fin_status_n = ST_NOT_QUEUED;
								state_n      = S_DONE;
							end else begin
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = head_q;
								pos_n           = '0;
								state_n         = S_CAN_CMP;
							end
						end
						MODE_TICK: begin
							pops_n   = '0;
							pend_v_n = 1'b0;
							if (count_q == '0) begin
								fin_status_n = ST_NONE;
								fin_n        = '0;
								state_n      = S_DONE;
							end else begin
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = head_q;
								state_n         = S_TICK_CMP;
							end
						end
						default: begin
							state_n = S_IDLE;
						end
					endcase
				end
			end

			// Walk from the tail toward the head, moving later deadlines up one cell.
			S_INS_CMP: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = phys(head_q, pos_q);
				if (rd_data.deadline > dl_q) begin
					mem_req.wr_data = rd_data;
					pos_n           = pos_q - ADDR_W'(1);
					if (pos_q == ADDR_W'(1)) begin
						state_n = S_INS_PUT;
					end else begin
						mem_req.rd_en   = 1'b1;
						mem_req.rd_addr = phys(head_q, pos_q - ADDR_W'(2));
					end
				end else begin
					mem_req.wr_data  = '{deadline: dl_q, id: id_q};
					count_n          = count_q + CNT_W'(1);
					queued_n[id_q]   = 1'b1;
					fin_status_n     = ST_INSERTED;
					state_n          = S_DONE;
				end
			end

			// The new entry goes to the head cell.
			S_INS_PUT: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = phys(head_q, pos_q);
				mem_req.wr_data = '{deadline: dl_q, id: id_q};
				count_n         = count_q + CNT_W'(1);
				queued_n[id_q]  = 1'b1;
				fin_status_n    = ST_INSERTED;
				state_n         = S_DONE;
			end

			// Search from the head for the id to cancel.
			S_CAN_CMP: begin
				if (rd_data.id == id_q) begin
					if (pos_up < count_q) begin
						mem_req.rd_en   = 1'b1;
						mem_req.rd_addr = phys(head_q, ADDR_W'(pos_up));
						state_n         = S_CAN_SH;
					end else begin
						count_n        = count_q - CNT_W'(1);
						queued_n[id_q] = 1'b0;
						fin_status_n   = ST_CANCELLED;
						state_n        = S_DONE;
					end
				end else if (pos_up < count_q) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = phys(head_q, ADDR_W'(pos_up));
					pos_n           = ADDR_W'(pos_up);
				end else begin
					queued_n[id_q] = 1'b0;
					fin_status_n   = ST_CANCELLED;
					state_n        = S_DONE;
				end
			end

			// Close the gap: each later cell moves one place toward the head.
			S_CAN_SH: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = phys(head_q, pos_q);
				mem_req.wr_data = rd_data;
				pos_n           = ADDR_W'(pos_up);
				if ((pos_up + CNT_W'(1)) < count_q) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = phys(head_q, ADDR_W'(pos_up + CNT_W'(1)));
				end else begin
					count_n        = count_q - CNT_W'(1);
					queued_n[id_q] = 1'b0;
					fin_status_n   = ST_CANCELLED;
					state_n        = S_DONE;
				end
			end

			// Pop expired heads; each is held back until the next one is known.
			S_TICK_CMP: begin
				if (expire) begin
					if (!pend_v_q || res_free) begin
						if (pend_v_q) begin
							res_push = 1'b1;
							res_data = '{status: ST_EXPIRED, id: pend_q.id,
								deadline: pend_q.deadline, last: 1'b0};
						end
						head_n               = phys(head_q, ADDR_W'(1));
						count_n              = count_q - CNT_W'(1);
						pops_n               = pops_q + POP_W'(1);
						queued_n[rd_data.id] = 1'b0;
						if ((count_q > CNT_W'(1)) && (pops_q + POP_W'(1) < POP_W'(ID_COUNT)))
						begin
							pend_v_n        = 1'b1;
							pend_n          = rd_data;
							mem_req.rd_en   = 1'b1;
							mem_req.rd_addr = phys(head_q, ADDR_W'(1));
						end else begin
							pend_v_n     = 1'b0;
							fin_status_n = ST_EXPIRED;
							fin_n        = rd_data;
							state_n      = S_DONE;
						end
					end
				end else begin
					pend_v_n = 1'b0;
					if (pend_v_q) begin
						fin_status_n = ST_EXPIRED;
						fin_n        = pend_q;
					end else begin
						fin_status_n = ST_NONE;
						fin_n        = '0;
					end
					state_n = S_DONE;
				end
			end

			// Hand over the final result of the command.
			S_DONE: begin
				if (res_free) begin
					res_push = 1'b1;
					res_data = '{status: fin_status_q, id: fin_q.id,
						deadline: fin_q.deadline, last: 1'b1};
					state_n  = S_IDLE;
				end
			end

			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			queued_q <= '0;
			pend_v_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			head_q   <= head_n;
			count_q  <= count_n;
			queued_q <= queued_n;
			pend_v_q <= pend_v_n;
		end
	end

	// Working registers of the current command.
	always_ff @(posedge clk) begin
		pos_q        <= pos_n;
		pops_q       <= pops_n;
		id_q         <= id_n;
		dl_q         <= dl_n;
		now_q        <= now_n;
		pend_q       <= pend_n;
		fin_status_q <= fin_status_n;
		fin_q        <= fin_n;
	end

	// The fill count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("queue count above capacity");

	// Between commands, the number of queued id bits equals the fill count.
	a_queued_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ($countones(queued_q) == int'(count_q)))
		else $error("queued id bits disagree with count");

	// A cell is never read and written in the same cycle.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
		else $error("read and write hit the same cell");

	// Results are only produced when the result register can take them.
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> res_free)
		else $error("result pushed into a busy register");

endmodule
`default_nettype wire

>>> rtl/deadline_timer_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the deadline timer queue: controller, entry store and result register.
// Depends on dtq_pkg, dtq_if, dtq_store and dtq_ctrl.
//
//  Channel | Direction | Payload                                   | Transfer when
//  cmd     | in        | mode, entry_id, deadline, now_time        | cmd.valid && cmd.ready
//  rsp     | out       | status, result_id, result_deadline, last  | rsp.valid && rsp.ready
//
// A command is taken only while the sequencer is idle. A rejected insert or cancel, an insert
// into an empty queue and a tick on an empty queue go straight to the result; any other
// insert moves each later entry up one cell, and a cancel walks all queued entries.
// A tick on a filled queue pops expired heads until an unexpired head, an empty queue or
// the pop limit ends it, with one store read per examined head. Reset clears count, head
// and id bits at once; the store needs no clearing. A stalled result register holds the
// sequencer.
module deadline_timer_queue import dtq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	dtq_cmd_if.sink   cmd,
	dtq_rsp_if.source rsp
);

	mem_req_t mem_req;
	entry_t   rd_data;
	logic     res_free;
	logic     res_push;
	result_t  res_data;
	logic     res_v_q;
	result_t  res_q;

	dtq_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	dtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.mem_req  (mem_req),
		.rd_data  (rd_data),
		.res_free (res_free),
		.res_push (res_push),
		.res_data (res_data)
	);

	// Output register; refilled in the cycle its content transfers.
	assign res_free = !res_v_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (res_free) begin
			res_v_q <= res_push;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_push) begin
			res_q <= res_data;
		end
	end

	assign rsp.valid           = res_v_q;
	assign rsp.status          = res_q.status;
	assign rsp.result_id       = res_q.id;
	assign rsp.result_deadline = res_q.deadline;
	assign rsp.last            = res_q.last;

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Regression bench for the deadline timer queue: random and directed commands
// with a sorted-queue predictor in a scoreboard class. Depends on dtq_pkg, dtq_if and deadline_timer_queue.
module testbench;
	import dtq_pkg::*;

	logic clk;
	logic arst_n;
	logic failed;

	dtq_cmd_if cmd ();
	dtq_rsp_if rsp ();

	deadline_timer_queue dut (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp));

	// Predictor of the timer queue plus the store of pending results.
	class timer_scoreboard;
		logic [TIME_BITS-1:0] cell_deadline[$];
		logic [ID_W-1:0]      cell_id[$];
		bit                   queued[ID_COUNT];
		result_t              pending[$];
		int                   errors;

		function void push(status_t st, logic [ID_W-1:0] id, logic [TIME_BITS-1:0] dl,
				logic lst);
			result_t r;
			r.status = st;
			r.id = id;
			r.deadline = dl;
			r.last = lst;
			pending.push_back(r);
		endfunction

		// Apply one accepted command and queue the results it causes.
		function void note_command(logic [1:0] mode, logic [ID_W-1:0] id,
				logic [TIME_BITS-1:0] dl, logic [TIME_BITS-1:0] now);
			int pos;
			int n;
			case (mode)
				MODE_INSERT: begin
					if (queued[id]) push(ST_DUPLICATE, id, '0, 1'b1);
					else if (cell_id.size() >= CAPACITY) push(ST_FULL, id, '0, 1'b1);
					else begin
						pos = cell_id.size();
						while (pos > 0 && cell_deadline[pos-1] > dl) pos--;
						cell_deadline.insert(pos, dl);
						cell_id.insert(pos, id);
						queued[id] = 1'b1;
						push(ST_INSERTED, id, '0, 1'b1);
					end
				end
				MODE_CANCEL: begin
					if (!queued[id]) push(ST_NOT_QUEUED, id, '0, 1'b1);
					else begin
						for (pos = 0; pos < cell_id.size(); pos++)
							if (cell_id[pos] == id) break;
						if (pos < cell_id.size()) begin
							cell_id.delete(pos);
							cell_deadline.delete(pos);
						end
						queued[id] = 1'b0;
						push(ST_CANCELLED, id, '0, 1'b1);
					end
				end
				MODE_TICK: begin
					n = 0;
					while (cell_id.size() > 0 && now >= cell_deadline[0] && n < ID_COUNT) begin
						push(ST_EXPIRED, cell_id[0], cell_deadline[0], 1'b0);
						queued[cell_id[0]] = 1'b0;
						void'(cell_id.pop_front());
						void'(cell_deadline.pop_front());
						n++;
					end
					if (n == 0) push(ST_NONE, '0, '0, 1'b1);
					else pending[pending.size()-1].last = 1'b1;
				end
				default: ;
			endcase
		endfunction

		// Compare one result transfer with the oldest expectation.
		function void check_result(logic [2:0] st, logic [ID_W-1:0] id,
				logic [TIME_BITS-1:0] dl, logic lst);
			result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result status=%0d id=%0d", st, id);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, st);
				errors++;
			end
			if (id !== e.id) begin
				$error("result_id: expected %0d, actual %0d", e.id, id);
				errors++;
			end
			if (dl !== e.deadline) begin
				$error("result_deadline: expected %0h, actual %0h", e.deadline, dl);
				errors++;
			end
			if (lst !== e.last) begin
				$error("last: expected %0d, actual %0d", e.last, lst);
				errors++;
			end
		endfunction
	endclass

	timer_scoreboard board;
	bit rsp_stall_enable;

	// Gap length: mostly short, sometimes long.
	function automatic int gap_length();
		if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 2);
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("deadline_timer_queue regression: fail");
		$finish;
	end

	// Drive one command and wait for its transfer.
	task automatic send_command(logic [1:0] mode, logic [ID_W-1:0] id,
			logic [TIME_BITS-1:0] dl, logic [TIME_BITS-1:0] now, bit allow_gap);
		int gap;
		gap = allow_gap ? gap_length() : 0;
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.mode <= mode;
		cmd.entry_id <= id;
		cmd.deadline <= dl;
		cmd.now_time <= now;
		do @(posedge clk); while (!cmd.ready);
		board.note_command(mode, id, dl, now);
	endtask

	task automatic wait_drained();
		cmd.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Result side: sample transfers and stall the ready at random.
	initial begin
		int stall;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				board.check_result(rsp.status, rsp.result_id, rsp.result_deadline, rsp.last);
			stall = rsp_stall_enable ? gap_length() : 0;
			if (stall > 0 && $urandom_range(0, 3) == 0) begin
				rsp.ready <= 1'b0;
				repeat (stall - 1) begin
					@(posedge clk);
				end
				@(posedge clk);
				if (rsp.valid && rsp.ready)
					board.check_result(rsp.status, rsp.result_id, rsp.result_deadline,
						rsp.last);
			end
			rsp.ready <= 1'b1;
		end
	end

	// Stimulus.
	initial begin
		int i;
		int kind;
		logic [TIME_BITS-1:0] base;
		board = new();
		rsp_stall_enable = 1'b0;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.mode = MODE_INSERT;
		cmd.entry_id = '0;
		cmd.deadline = '0;
		cmd.now_time = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty tick, cancel missing, extremes, ties, full, duplicate.
		send_command(MODE_TICK, 4'd0, '0, '0, 0);
		send_command(MODE_CANCEL, 4'd15, '0, '0, 0);
		send_command(MODE_INSERT, 4'd0, '1, '0, 0);
		send_command(MODE_INSERT, 4'd15, '0, '0, 0);
		send_command(MODE_INSERT, 4'd15, 32'd5, '0, 0);
		send_command(MODE_INSERT, 4'd3, 32'd100, '1, 0);
		send_command(MODE_INSERT, 4'd4, 32'd100, '0, 0);
		send_command(2'd3, 4'd9, '1, '1, 0);
		send_command(MODE_CANCEL, 4'd3, '0, '0, 0);
		for (i = 5; i < 15; i++) send_command(MODE_INSERT, i[3:0], 32'd50, '0, 0);
		send_command(MODE_INSERT, 4'd1, 32'd7, '0, 0);
		send_command(MODE_INSERT, 4'd2, 32'd7, '0, 0);
		send_command(MODE_INSERT, 4'd3, 32'd7, '0, 0);
		send_command(MODE_TICK, 4'd0, '0, 32'hAAAA_5555, 0);
		send_command(MODE_TICK, 4'd0, '0, '1, 0);
		wait_drained();

		// Random: mostly small time window so ticks find expired entries.
		rsp_stall_enable = 1'b1;
		base = '0;
		for (i = 0; i < 210; i++) begin
			if (i == 100) wait_drained();
			kind = $urandom_range(0, 19);
			if (kind < 9)
				send_command(MODE_INSERT, 4'($urandom), (kind == 0) ? 32'($urandom) :
					base + 32'($urandom_range(0, 60)), '0, 1);
			else if (kind < 13)
				send_command(MODE_CANCEL, 4'($urandom), 32'($urandom), '0, 1);
			else if (kind < 19) begin
				base = base + 32'($urandom_range(0, 30));
				send_command(MODE_TICK, 4'($urandom), 32'($urandom),
					(kind == 18) ? 32'($urandom) : base, 1);
			end else
				send_command(2'd3, 4'($urandom), 32'($urandom), 32'($urandom), 1);
		end
		wait_drained();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("deadline_timer_queue regression: pass");
		else
			$display("deadline_timer_queue regression: fail");
		$finish;
	end
endmodule

>>> filelist.f
rtl/dtq_pkg.sv
rtl/dtq_if.sv
rtl/dtq_store.sv
rtl/dtq_ctrl.sv
rtl/deadline_timer_queue.sv
bench/testbench.sv
